>>> rtl/touch_double_click_detector_core_assert.svh
// Assertion helpers for the RTL files of the touch double-click detector.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef TOUCH_DOUBLE_CLICK_DETECTOR_CORE_ASSERT_SVH
`define TOUCH_DOUBLE_CLICK_DETECTOR_CORE_ASSERT_SVH

// Checked only outside reset.
`define TDCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TDCD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/tdcd_pkg.sv
`default_nettype none

package tdcd_pkg;

	localparam int COORD_BITS = 10;
	localparam int WIN_BITS   = 16;

	localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd500;

	localparam logic OP_TOUCH = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		KIND_PRESS   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_DOUBLE  = 2'd2
	} kind_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   operation;
		coord_t touch_x;
		coord_t touch_y;
		logic   pressed;
	} in_beat_t;

	typedef struct packed {
		kind_t  event_kind;
		coord_t event_x;
		coord_t event_y;
		logic   last_of_run;
	} out_beat_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} xy_t;

	// Results of one processed item: count, then up to two beats in order.
	typedef struct packed {
		logic [1:0] n;
		out_beat_t  r0;
		out_beat_t  r1;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/tdcd_core.sv
`default_nettype none

module tdcd_core import tdcd_pkg::*; #(
	parameter int AGE_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [WIN_BITS-1:0] cfg_wdata,
	input  wire in_beat_t            item,
	input  wire logic                go,
	output res_t                     res
);

	localparam int CMP_W = (AGE_BITS > WIN_BITS) ? AGE_BITS : WIN_BITS;

	logic [WIN_BITS-1:0] win_q;
	logic                press_pending_q;
	logic                release_pending_q;
	xy_t                 press_xy_q;
	xy_t                 release_xy_q;
	logic [AGE_BITS-1:0] press_age_q;
	logic [AGE_BITS-1:0] release_age_q;

	logic [AGE_BITS-1:0] press_age_inc;
	logic [AGE_BITS-1:0] release_age_inc;
	logic [CMP_W-1:0]    win_c;
	logic                is_tick;
	logic                emit_p;
	logic                emit_r;
	logic                dbl;
	out_beat_t           press_beat;
	out_beat_t           release_beat;

	always_comb begin
		press_age_inc   = (press_age_q == '1) ? press_age_q : press_age_q + 1'b1;
		release_age_inc = (release_age_q == '1) ? release_age_q : release_age_q + 1'b1;
		win_c   = CMP_W'(win_q);
		is_tick = (item.operation == OP_TICK);
		emit_p  = is_tick && press_pending_q && (CMP_W'(press_age_inc) >= win_c);
		emit_r  = is_tick && release_pending_q && (CMP_W'(release_age_inc) >= win_c);
		dbl     = !is_tick && !item.pressed && release_pending_q
			&& (CMP_W'(release_age_q) < win_c);

		press_beat   = '{event_kind: KIND_PRESS, event_x: press_xy_q.x,
			event_y: press_xy_q.y, last_of_run: !emit_r};
		release_beat = '{event_kind: KIND_RELEASE, event_x: release_xy_q.x,
			event_y: release_xy_q.y, last_of_run: 1'b1};

		res.n  = 2'd0;
		res.r0 = press_beat;
		res.r1 = release_beat;
		if (dbl) begin
			res.n  = 2'd1;
			res.r0 = '{event_kind: KIND_DOUBLE, event_x: item.touch_x,
				event_y: item.touch_y, last_of_run: 1'b1};
		end else if (emit_p) begin
			res.n = emit_r ? 2'd2 : 2'd1;
		end else if (emit_r) begin
			res.n  = 2'd1;
			res.r0 = release_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q             <= WIN_RESET;
			press_pending_q   <= 1'b0;
			release_pending_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				win_q <= cfg_wdata;
			end
			if (go) begin
				if (is_tick) begin
					if (emit_p) press_pending_q <= 1'b0;
					if (emit_r) release_pending_q <= 1'b0;
				end else if (item.pressed) begin
					press_pending_q <= 1'b1;
				end else if (!release_pending_q) begin
					release_pending_q <= 1'b1;
				end else if (dbl) begin
					press_pending_q   <= 1'b0;
					release_pending_q <= 1'b0;
				end
			end
		end
	end

	// Coordinates and ages only matter while the matching pending bit is set.
	always_ff @(posedge clk) begin
		if (go) begin
			if (is_tick) begin
				if (press_pending_q) press_age_q <= press_age_inc;
				if (release_pending_q) release_age_q <= release_age_inc;
			end else if (item.pressed) begin
				if (!press_pending_q) begin
					press_xy_q  <= '{x: item.touch_x, y: item.touch_y};
					press_age_q <= '0;
				end
			end else if (!release_pending_q) begin
				release_xy_q  <= '{x: item.touch_x, y: item.touch_y};
				release_age_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/tdcd_outbuf.sv
`default_nettype none

`include "touch_double_click_detector_core_assert.svh"

module tdcd_outbuf import tdcd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  valid_s1,
	input  wire res_t  res,
	input  wire logic  out_stall,
	output logic       go,
	output logic       out_valid,
	output out_beat_t  out_data
);

	// Two result slots: hd_q drives the port, nx_q waits behind it.
	logic [1:0] cnt_q;
	out_beat_t  hd_q;
	out_beat_t  nx_q;

	logic       pop;
	logic [1:0] kept;
	logic [1:0] n_eff;
	logic [2:0] fill;
	out_beat_t  base0;
	out_beat_t  hd_d;
	out_beat_t  nx_d;

	always_comb begin
		pop   = (cnt_q != 2'd0) && !out_stall;
		kept  = cnt_q - {1'b0, pop};
		fill  = {1'b0, kept} + {1'b0, res.n};
		go    = valid_s1 && (fill <= 3'd2);
		n_eff = go ? res.n : 2'd0;
		base0 = pop ? nx_q : hd_q;
		case (kept)
			2'd0: begin
				hd_d = res.r0;
				nx_d = res.r1;
			end
			2'd1: begin
				hd_d = base0;
				nx_d = res.r0;
			end
			default: begin
				hd_d = base0;
				nx_d = nx_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= kept + n_eff;
		end
	end

	always_ff @(posedge clk) begin
		hd_q <= hd_d;
		nx_q <= nx_d;
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = hd_q;

	`TDCD_ASSERT(a_cnt_range, (cnt_q <= 2'd2), "result buffer count out of range")
	`TDCD_ASSERT(a_no_overflow, ((kept == 2'd2) |-> (n_eff == 2'd0)), "push into full buffer")
	`TDCD_ASSERT(a_pair_order,
		((cnt_q == 2'd0 && n_eff == 2'd2) |=> (cnt_q == 2'd2 && !hd_q.last_of_run && nx_q.last_of_run)),
		"two-beat run lost its order")

endmodule

`default_nettype wire

>>> rtl/touch_double_click_detector_core.sv
// Touch double-click detector.
// Input channel in_valid/in_stall/in_data carries one beat per touch event
// (operation = touch) or per millisecond tick (operation = tick).
// Output channel out_valid/out_stall/out_data carries delayed press, delayed
// release and double-click beats; last_of_run marks the final beat of an item.
// cfg_we/cfg_wdata write the double-click window in ticks (reset 500).
// An accepted beat waits in a one-entry input register until the result buffer
// can take its results; they are then written into the result buffer registers,
// whose head slot drives the output port.
// Throughput is one beat per cycle while the output is taken and the result
// buffer has room; an item that makes two results fills both result slots.
// in_stall rises only when the buffer cannot absorb the waiting item's results.
// While out_stall is high the head beat holds and the input keeps flowing until
// the waiting item's results no longer fit in the result buffer.
// Reset clears all pending presses and releases and empties both buffers.
`default_nettype none

module touch_double_click_detector_core import tdcd_pkg::*; #(
	parameter int AGE_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_beat_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_beat_t                out_data,
	input  wire logic                cfg_we,
	input  wire logic [WIN_BITS-1:0] cfg_wdata
);

	logic     valid_s1;
	in_beat_t item_s1;
	logic     go;
	res_t     res;

	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	tdcd_core #(
		.AGE_BITS(AGE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_s1),
		.go       (go),
		.res      (res)
	);

	tdcd_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.out_stall(out_stall),
		.go       (go),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
